// ===== hdl/mesi_pkg.sv =====
// shared types and constants of the mesi snooping cache controller
package mesi_pkg;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_SNRD  = 2'd2;
	localparam logic [1:0] KIND_SNINV = 2'd3;

	localparam logic [2:0] ST_EMPTY     = 3'd0;
	localparam logic [2:0] ST_INVALID   = 3'd1;
	localparam logic [2:0] ST_SHARED    = 3'd2;
	localparam logic [2:0] ST_EXCLUSIVE = 3'd3;
	localparam logic [2:0] ST_MODIFIED  = 3'd4;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_BUSRD = 2'd1;
	localparam logic [1:0] CMD_RDX   = 2'd2;
	localparam logic [1:0] CMD_INV   = 2'd3;

	localparam logic [9:0] PEN_WB    = 10'd100;
	localparam logic [9:0] PEN_EXCL  = 10'd100;
	localparam logic [9:0] PEN_WMISS = 10'd200;

	typedef struct packed {
		logic hit;
		logic retry;
		logic snoop_found;
		logic [1:0] bus_command;
		logic writeback;
		logic evicted;
		logic [9:0] penalty_cycles;
		logic [1:0] data_blocks;
	} mesi_result_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the item and start the set read
		logic update;    // write the updated set and form the result
	} mesi_cmd_t;

endpackage

// ===== hdl/mesi_ctrl.sv =====
// controller state machine: capture, update, present result
module mesi_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output mesi_pkg::mesi_cmd_t cmd
);
	import mesi_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic start;

	// a new item may enter while the finished result is being taken
	assign in_ready  = (state_q == S_IDLE) || (state_q == S_DONE && out_ready);
	assign out_valid = (state_q == S_DONE);
	assign start     = in_valid && in_ready;
	assign cmd.capture = start;
	assign cmd.update  = (state_q == S_LOOK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_LOOK;
				end
				S_LOOK: state_q <= S_DONE;
				S_DONE: begin
					if (start) state_q <= S_LOOK;
					else if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/mesi_dp.sv =====
// datapath: tag, state and stamp arrays with lookup, victim choice and update
module mesi_dp #(
	parameter int SET_BITS = 6,
	parameter int WAYS = 2,
	parameter int BLOCK_BITS = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  mesi_pkg::mesi_cmd_t cmd,
	input  logic [1:0] kind,
	input  logic [31:0] address,
	input  logic [31:0] cycle_now,
	input  logic bus_busy,
	input  logic others_share,
	output mesi_pkg::mesi_result_t result
);
	import mesi_pkg::*;

	localparam int SETS = 1 << SET_BITS;
	localparam int TAG_W = 32 - SET_BITS - BLOCK_BITS;
	localparam int SET_W = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [9:0] PEN_SHARE = 10'(2 * (1 << (BLOCK_BITS - 2)));

	// one memory row per set holds all ways
	logic [WAYS-1:0][TAG_W-1:0] tag_mem [SETS];
	logic [WAYS-1:0][31:0]      use_mem [SETS];
	logic [WAYS-1:0][2:0]       coh_mem [SETS];
	logic [SETS-1:0]            row_valid_q;   // row written since reset

	logic [WAYS-1:0][TAG_W-1:0] tag_s1;
	logic [WAYS-1:0][31:0]      use_raw_s1;
	logic [WAYS-1:0][2:0]       coh_raw_s1;
	logic                       rv_s1;
	logic [1:0]  kind_s1;
	logic [TAG_W-1:0] atag_s1;
	logic [SET_W-1:0] set_s1;
	logic [31:0] now_s1;
	logic busy_s1, share_s1;
	logic [SET_W-1:0] set_in;

	assign set_in = (SET_BITS > 0) ? SET_W'(address >> BLOCK_BITS) : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tag_s1     <= tag_mem[set_in];
			use_raw_s1 <= use_mem[set_in];
			coh_raw_s1 <= coh_mem[set_in];
			kind_s1  <= kind;
			atag_s1  <= TAG_W'(address >> (SET_BITS + BLOCK_BITS));
			set_s1   <= set_in;
			now_s1   <= cycle_now;
			busy_s1  <= bus_busy;
			share_s1 <= others_share;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s1 <= 1'b0;
		else if (cmd.capture) rv_s1 <= row_valid_q[set_in];
	end

	logic [WAYS-1:0][31:0] use_s1;
	logic [WAYS-1:0][2:0]  coh_s1;
	logic [WAYS-1:0][2:0]  coh_nx;
	logic [WAYS-1:0][TAG_W-1:0] tag_nx;
	logic [WAYS-1:0][31:0] use_nx;
	logic found;
	logic [WAY_W-1:0] way, vic, best;
	logic free_found;
	logic [2:0] wst, vst;
	mesi_result_t res;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			use_s1[w] = rv_s1 ? use_raw_s1[w] : 32'd0;
			coh_s1[w] = rv_s1 ? coh_raw_s1[w] : ST_EMPTY;
		end
		found = 1'b0;
		way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (coh_s1[w] != ST_EMPTY && tag_s1[w] == atag_s1) begin
				found = 1'b1;
				way = WAY_W'(w);
			end
		end
		free_found = 1'b0;
		vic = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (coh_s1[w] == ST_EMPTY || coh_s1[w] == ST_INVALID) begin
				free_found = 1'b1;
				vic = WAY_W'(w);
			end
		end
		best = '0;
		for (int w = 1; w < WAYS; w++) begin
			if (use_s1[w] < use_s1[best]) best = WAY_W'(w);
		end
		if (!free_found) vic = best;
		wst = coh_s1[way];
		vst = coh_s1[vic];
		coh_nx = coh_s1;
		tag_nx = tag_s1;
		use_nx = use_s1;
		res = '0;
		if (kind_s1 == KIND_READ || kind_s1 == KIND_WRITE) begin
			if (found) use_nx[way] = now_s1;
			if (found && wst != ST_INVALID) begin
				res.hit = 1'b1;
				if (kind_s1 == KIND_WRITE) begin
					if (wst == ST_SHARED) begin
						if (busy_s1) res.retry = 1'b1;
						else begin
							res.bus_command = CMD_INV;
							coh_nx[way] = ST_MODIFIED;
						end
					end else begin
						coh_nx[way] = ST_MODIFIED;
					end
				end
			end else if (busy_s1) begin
				res.hit = 1'b1;
				res.retry = 1'b1;
			end else begin
				res.evicted = (vst != ST_EMPTY);
				if (vst == ST_MODIFIED) begin
					res.writeback = 1'b1;
					res.penalty_cycles = PEN_WB;
					res.data_blocks = 2'd1;
				end
				tag_nx[vic] = atag_s1;
				use_nx[vic] = now_s1;
				res.data_blocks = res.data_blocks + 2'd1;
				if (kind_s1 == KIND_READ) begin
					res.bus_command = CMD_BUSRD;
					coh_nx[vic] = share_s1 ? ST_SHARED : ST_EXCLUSIVE;
					res.penalty_cycles = res.penalty_cycles
						+ (share_s1 ? PEN_SHARE : PEN_EXCL);
				end else begin
					res.bus_command = CMD_RDX;
					coh_nx[vic] = ST_MODIFIED;
					res.penalty_cycles = res.penalty_cycles + PEN_WMISS;
				end
			end
		end else if (found && wst != ST_INVALID) begin
			res.snoop_found = 1'b1;
			if (wst == ST_MODIFIED) begin
				res.writeback = 1'b1;
				res.penalty_cycles = PEN_WB;
			end
			if (kind_s1 == KIND_SNRD) begin
				res.data_blocks = 2'd1;
				coh_nx[way] = ST_SHARED;
			end else begin
				res.data_blocks = (wst == ST_MODIFIED) ? 2'd1 : 2'd0;
				coh_nx[way] = ST_INVALID;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			tag_mem[set_s1] <= tag_nx;
			use_mem[set_s1] <= use_nx;
			coh_mem[set_s1] <= coh_nx;
			result <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) row_valid_q <= '0;
		else if (cmd.update) row_valid_q[set_s1] <= 1'b1;
	end
endmodule

// ===== hdl/mesi_snooping_cache_controller_core.sv =====
// top level of the mesi snooping cache controller
//
// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready       tdata {others_share,bus_busy,cycle_now,address}, tuser kind
// m_axis   out  m_axis_tvalid/tready       tdata result fields
//
// each transfer reads the set row, then writes the row back and registers the result
// a new input transfer is taken in the cycle the result is taken
// a stalled result holds the block; reset clears the state machine and row valid bits
// rows never written read as empty lines with zero stamps, so no clearing pass
module mesi_snooping_cache_controller_core #(
	parameter int SET_BITS = 6,
	parameter int WAYS = 2,
	parameter int BLOCK_BITS = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// address [31:0], cycle_now [63:32], bus_busy [64], others_share [65], zero fill
	input  logic [71:0] s_axis_tdata,
	// kind [1:0]
	input  logic [1:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hit [0], retry [1], snoop_found [2], bus_command [4:3], writeback [5],
	// evicted [6], penalty_cycles [16:7], data_blocks [18:17], zero fill
	output logic [23:0] m_axis_tdata
);
	import mesi_pkg::*;

	mesi_cmd_t cmd;
	mesi_result_t result;

	mesi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd)
	);

	mesi_dp #(.SET_BITS(SET_BITS), .WAYS(WAYS), .BLOCK_BITS(BLOCK_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.kind(s_axis_tuser),
		.address(s_axis_tdata[31:0]),
		.cycle_now(s_axis_tdata[63:32]),
		.bus_busy(s_axis_tdata[64]),
		.others_share(s_axis_tdata[65]),
		.result(result)
	);

	assign m_axis_tdata = {5'd0, result.data_blocks, result.penalty_cycles,
		result.evicted, result.writeback, result.bus_command,
		result.snoop_found, result.retry, result.hit};

	// a retry always reports a hit
	a_retry_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (!m_axis_tdata[1] || m_axis_tdata[0]))
		else $error("retry without hit");

	// a lookup is followed by a presented result
	a_look_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> m_axis_tvalid)
		else $error("result not presented after update");

	// no input is taken while a result stalls
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken during output stall");
endmodule

// ===== tb/mesi_snooping_cache_controller_core_tb.sv =====
// testbench for the mesi snooping cache controller core: random and directed accesses and snoops
`timescale 1ns / 100ps

module mesi_snooping_cache_controller_core_tb;

	import mesi_pkg::*;

	localparam int SET_BITS = 6;
	localparam int WAYS = 2;
	localparam int BLOCK_BITS = 5;
	localparam int NUM_SETS = 1 << SET_BITS;
	localparam int TAG_BITS = 32 - SET_BITS - BLOCK_BITS;
	localparam int HOLD_CYCLES = 60;

	typedef struct {
		logic [1:0] kind;
		logic [31:0] address;
		logic [31:0] cycle_now;
		logic bus_busy;
		logic others_share;
		bit wait_drain;   // sender pauses until every expected result is in
	} access_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [71:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;

	mesi_snooping_cache_controller_core #(
		.SET_BITS(SET_BITS), .WAYS(WAYS), .BLOCK_BITS(BLOCK_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the cache directory
	logic [TAG_BITS-1:0] shadow_tag [NUM_SETS][WAYS];
	logic [2:0] shadow_state [NUM_SETS][WAYS];
	logic [31:0] shadow_stamp [NUM_SETS][WAYS];

	access_t pending_accesses[$];
	mesi_result_t expected_results[$];
	int error_count = 0;
	bit stimulus_done = 1'b0;
	bit hold_off_request = 1'b0;
	// small tag pool so lines get reused, hit, conflict and evict
	logic [TAG_BITS-1:0] tag_pool [8];

	// computes the result of one access and updates the shadow directory
	function automatic mesi_result_t cache_access(access_t a);
		mesi_result_t r;
		int set_idx;
		logic [TAG_BITS-1:0] tag;
		int way;
		int victim;
		bit dirty;
		r = '0;
		set_idx = int'(a.address[BLOCK_BITS +: SET_BITS]);
		tag = a.address[31 -: TAG_BITS];
		way = -1;
		for (int w = WAYS - 1; w >= 0; w--)
			if (shadow_state[set_idx][w] != ST_EMPTY && shadow_tag[set_idx][w] == tag)
				way = w;
		if (a.kind == KIND_READ || a.kind == KIND_WRITE) begin
			if (way >= 0)
				shadow_stamp[set_idx][way] = a.cycle_now;
			if (way >= 0 && shadow_state[set_idx][way] != ST_INVALID) begin
				r.hit = 1'b1;
				if (a.kind == KIND_WRITE) begin
					if (shadow_state[set_idx][way] == ST_SHARED) begin
						if (a.bus_busy)
							r.retry = 1'b1;
						else begin
							r.bus_command = CMD_INV;
							shadow_state[set_idx][way] = ST_MODIFIED;
						end
					end else
						shadow_state[set_idx][way] = ST_MODIFIED;
				end
			end else if (a.bus_busy) begin
				r.hit = 1'b1;
				r.retry = 1'b1;
			end else begin
				// free way first, else oldest stamp with ties to the lowest way
				victim = -1;
				for (int w = WAYS - 1; w >= 0; w--)
					if (shadow_state[set_idx][w] == ST_EMPTY
							|| shadow_state[set_idx][w] == ST_INVALID)
						victim = w;
				if (victim < 0) begin
					victim = 0;
					for (int w = 1; w < WAYS; w++)
						if (shadow_stamp[set_idx][w] < shadow_stamp[set_idx][victim])
							victim = w;
				end
				if (shadow_state[set_idx][victim] != ST_EMPTY)
					r.evicted = 1'b1;
				if (shadow_state[set_idx][victim] == ST_MODIFIED) begin
					r.writeback = 1'b1;
					r.penalty_cycles = PEN_WB;
					r.data_blocks = 2'd1;
				end
				shadow_tag[set_idx][victim] = tag;
				shadow_stamp[set_idx][victim] = a.cycle_now;
				r.data_blocks = r.data_blocks + 2'd1;
				if (a.kind == KIND_READ) begin
					r.bus_command = CMD_BUSRD;
					shadow_state[set_idx][victim] = a.others_share ? ST_SHARED : ST_EXCLUSIVE;
					r.penalty_cycles = r.penalty_cycles
						+ (a.others_share ? 10'(2 << (BLOCK_BITS - 2)) : PEN_EXCL);
				end else begin
					r.bus_command = CMD_RDX;
					shadow_state[set_idx][victim] = ST_MODIFIED;
					r.penalty_cycles = r.penalty_cycles + PEN_WMISS;
				end
			end
		end else if (way >= 0 && shadow_state[set_idx][way] != ST_INVALID) begin
			dirty = shadow_state[set_idx][way] == ST_MODIFIED;
			r.snoop_found = 1'b1;
			if (dirty) begin
				r.writeback = 1'b1;
				r.penalty_cycles = PEN_WB;
			end
			if (a.kind == KIND_SNRD) begin
				r.data_blocks = 2'd1;
				shadow_state[set_idx][way] = ST_SHARED;
			end else begin
				r.data_blocks = dirty ? 2'd1 : 2'd0;
				shadow_state[set_idx][way] = ST_INVALID;
			end
		end
		return r;
	endfunction

	function automatic access_t make_access(logic [1:0] kind, logic [TAG_BITS-1:0] tag,
			int set_idx, logic [31:0] now, logic busy, logic share);
		access_t a;
		a.kind = kind;
		a.address = {tag, SET_BITS'(set_idx), BLOCK_BITS'($urandom)};
		a.cycle_now = now;
		a.bus_busy = busy;
		a.others_share = share;
		a.wait_drain = 1'b0;
		return a;
	endfunction

	// input transfer seen at the last rising edge
	bit in_taken = 1'b0;
	always @(posedge clk)
		in_taken <= s_axis_tvalid && s_axis_tready;

	// driver: presents queued accesses with random gaps
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && !in_taken) begin
				// holding the current transfer
			end else if (send_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_accesses.size() != 0
					&& !(pending_accesses[0].wait_drain && expected_results.size() != 0)) begin
				access_t a;
				a = pending_accesses.pop_front();
				s_axis_tdata <= {6'b0, a.others_share, a.bus_busy, a.cycle_now, a.address};
				s_axis_tuser <= a.kind;
				s_axis_tvalid <= 1'b1;
				expected_results.push_back(cache_access(a));
				// cheap way to get long runs without gaps
				send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// receiver stall: random per transfer, plus one long hold-off on request
	int recv_gap = 0;
	int hold_count = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_request && hold_count == 0) begin
				hold_count <= HOLD_CYCLES;
				hold_off_request <= 1'b0;
				m_axis_tready <= 1'b0;
			end else if (hold_count > 0) begin
				hold_count <= hold_count - 1;
				m_axis_tready <= hold_count == 1;
			end else if (m_axis_tready && m_axis_tvalid) begin
				recv_gap = $urandom_range(0, 4);
				m_axis_tready <= recv_gap == 0;
			end else if (recv_gap > 0) begin
				recv_gap = recv_gap - 1;
				m_axis_tready <= recv_gap == 0;
			end else
				m_axis_tready <= 1'b1;
		end
	end

	// monitor: compares each result transfer against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			mesi_result_t act;
			mesi_result_t exp_r;
			act.hit = m_axis_tdata[0];
			act.retry = m_axis_tdata[1];
			act.snoop_found = m_axis_tdata[2];
			act.bus_command = m_axis_tdata[4:3];
			act.writeback = m_axis_tdata[5];
			act.evicted = m_axis_tdata[6];
			act.penalty_cycles = m_axis_tdata[16:7];
			act.data_blocks = m_axis_tdata[18:17];
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected: %h", m_axis_tdata);
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (act.hit !== exp_r.hit) begin
					$error("hit: expected %0d, got %0d", exp_r.hit, act.hit);
					error_count++;
				end
				if (act.retry !== exp_r.retry) begin
					$error("retry: expected %0d, got %0d", exp_r.retry, act.retry);
					error_count++;
				end
				if (act.snoop_found !== exp_r.snoop_found) begin
					$error("snoop_found: expected %0d, got %0d", exp_r.snoop_found,
						act.snoop_found);
					error_count++;
				end
				if (act.bus_command !== exp_r.bus_command) begin
					$error("bus_command: expected %0d, got %0d", exp_r.bus_command,
						act.bus_command);
					error_count++;
				end
				if (act.writeback !== exp_r.writeback) begin
					$error("writeback: expected %0d, got %0d", exp_r.writeback, act.writeback);
					error_count++;
				end
				if (act.evicted !== exp_r.evicted) begin
					$error("evicted: expected %0d, got %0d", exp_r.evicted, act.evicted);
					error_count++;
				end
				if (act.penalty_cycles !== exp_r.penalty_cycles) begin
					$error("penalty_cycles: expected %0d, got %0d", exp_r.penalty_cycles,
						act.penalty_cycles);
					error_count++;
				end
				if (act.data_blocks !== exp_r.data_blocks) begin
					$error("data_blocks: expected %0d, got %0d", exp_r.data_blocks,
						act.data_blocks);
					error_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		access_t a;
		logic [31:0] now;
		int set_idx;
		for (int s = 0; s < NUM_SETS; s++)
			for (int w = 0; w < WAYS; w++) begin
				shadow_tag[s][w] = '0;
				shadow_state[s][w] = ST_EMPTY;
				shadow_stamp[s][w] = '0;
			end
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			tag_pool[i] = TAG_BITS'($urandom);
		now = 32'd10;

		// directed: fill, hits, write to shared busy and free, snoops, eviction, extremes
		pending_accesses.push_back(make_access(KIND_READ, tag_pool[0], 0, now, 1'b0, 1'b1));
		pending_accesses.push_back(make_access(KIND_WRITE, tag_pool[0], 0, now + 1, 1'b1, 1'b0));
		pending_accesses.push_back(make_access(KIND_WRITE, tag_pool[0], 0, now + 2, 1'b0, 1'b0));
		pending_accesses.push_back(make_access(KIND_READ, tag_pool[0], 0, now + 3, 1'b1, 1'b0));
		pending_accesses.push_back(make_access(KIND_SNRD, tag_pool[0], 0, now, 1'b0, 1'b0));
		pending_accesses.push_back(make_access(KIND_SNINV, tag_pool[0], 0, now, 1'b1, 1'b1));
		pending_accesses.push_back(make_access(KIND_SNINV, tag_pool[0], 0, now, 1'b0, 1'b0));
		// invalid match: refresh but miss, busy then free
		pending_accesses.push_back(make_access(KIND_READ, tag_pool[0], 0, now + 4, 1'b1, 1'b0));
		pending_accesses.push_back(make_access(KIND_READ, tag_pool[0], 0, now + 5, 1'b0, 1'b0));
		pending_accesses.push_back(make_access(KIND_WRITE, tag_pool[1], 0, 32'hFFFF_FFFF, 1'b0,
			1'b1));
		pending_accesses.push_back(make_access(KIND_WRITE, tag_pool[0], 0, now + 6, 1'b0, 1'b0));
		// set full, both modified: victim by stamp with writeback
		pending_accesses.push_back(make_access(KIND_WRITE, tag_pool[2], 0, 32'd0, 1'b0, 1'b0));
		pending_accesses.push_back(make_access(KIND_READ, tag_pool[3], 0, 32'd0, 1'b0, 1'b0));
		pending_accesses.push_back(make_access(KIND_SNRD, tag_pool[4], 0, now, 1'b0, 1'b0));
		pending_accesses.push_back(make_access(KIND_SNRD, tag_pool[1], 0, now, 1'b0, 1'b0));
		pending_accesses.push_back(make_access(KIND_READ, tag_pool[1], NUM_SETS - 1, 32'hFFFF_FFFF,
			1'b0, 1'b0));
		pending_accesses.push_back(make_access(KIND_WRITE, tag_pool[1], NUM_SETS - 1, now, 1'b0,
			1'b1));
		pending_accesses.push_back(make_access(KIND_SNINV, tag_pool[1], NUM_SETS - 1, now, 1'b0,
			1'b0));
		a = make_access(KIND_READ, tag_pool[1], NUM_SETS - 1, now, 1'b0, 1'b0);
		a.address[BLOCK_BITS-1:0] = '1;
		pending_accesses.push_back(a);

		// random: mostly a small working set with rising stamps, some wild addresses
		for (int i = 0; i < 1600; i++) begin
			now = now + $urandom_range(0, 3);
			set_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_SETS - 1)
				: $urandom_range(0, 3);
			a = make_access(2'($urandom), tag_pool[$urandom_range(0, 7)], set_idx,
				($urandom_range(0, 15) == 0) ? $urandom : now,
				$urandom_range(0, 4) == 0, 1'($urandom));
			if ($urandom_range(0, 19) == 0)
				a.address = $urandom;
			if (i == 800)
				a.wait_drain = 1'b1;
			pending_accesses.push_back(a);
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		// long receiver hold-off while the sender keeps offering
		repeat (40) @(posedge clk);
		hold_off_request = 1'b1;
		wait (pending_accesses.size() == 0 && !s_axis_tvalid);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("mesi_snooping_cache_controller_core_tb: done, clean");
		else
			$display("mesi_snooping_cache_controller_core_tb: done, errors");
		$finish;
	end

	// overall timeout
	initial begin
		#2_000_000;
		$display("mesi_snooping_cache_controller_core_tb: done, errors");
		$finish;
	end

endmodule
